// ===== hdl/unsigned_to_ascii_digits_defines.svh =====
// Assertion macros used by the digit converter top level.
`ifndef UNSIGNED_TO_ASCII_DIGITS_DEFINES_SVH
`define UNSIGNED_TO_ASCII_DIGITS_DEFINES_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define UTAD_ASSERT_HOLDS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// An antecedent that must be followed by a consequent in the same cycle.
`define UTAD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`else

`define UTAD_ASSERT_HOLDS(lbl, prop, msg)
`define UTAD_ASSERT_IMPLIES(lbl, ante, cons, msg)

`endif

`endif

// ===== hdl/utad_pkg.sv =====
// Package with widths, cell control types and the ASCII digit function.
package utad_pkg;

   // Width of the number to convert.
   localparam int VALUE_BITS = 32;

   // Digit cells needed for the largest decimal value, ceil(VALUE_BITS * log10(2)).
   localparam int DIGIT_CELLS = (VALUE_BITS * 30103 + 99999) / 100000;

   localparam int DIGIT_BITS     = 4;
   localparam int CHAR_BITS      = 7;
   localparam int REQ_TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((CHAR_BITS + 7) / 8) * 8;
   localparam int BIT_CNT_BITS   = $clog2(VALUE_BITS + 1);
   localparam int DIG_CNT_BITS   = $clog2(DIGIT_CELLS + 1);

   localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 7'd48;
   localparam logic [CHAR_BITS-1:0] ASCII_A    = 7'd65;
   localparam logic [DIGIT_BITS-1:0] DEC_ADJUST_MIN = 4'd5;
   localparam logic [DIGIT_BITS-1:0] DEC_ADJUST     = 4'd3;
   localparam logic [DIGIT_BITS-1:0] DEC_RADIX      = 4'd10;

   // Operation that all cells of the row perform together.
   typedef enum logic [1:0] {
      CELL_HOLD  = 2'd0,
      CELL_CLEAR = 2'd1,
      CELL_BIT   = 2'd2,
      CELL_DIGIT = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        hex;
   } cell_ctrl_type;

   // ASCII code of one digit, '0'-'9' or 'A'-'F'.
   function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] wide;
      wide = {{(CHAR_BITS - DIGIT_BITS){1'b0}}, d};
      if (d < DEC_RADIX) begin
         digit_to_ascii = ASCII_ZERO + wide;
      end else begin
         digit_to_ascii = ASCII_A + wide - {{(CHAR_BITS - DIGIT_BITS){1'b0}}, DEC_RADIX};
      end
   endfunction

endpackage

// ===== hdl/unsigned_to_ascii_digits.sv =====
// Top level: unsigned number to ASCII decimal or hexadecimal digits.
//
//   Channel | Direction | Contents
//   req_*   | in        | tdata: value; tuser: use_hex
//   rsp_*   | out       | tdata: char_code; tlast: last_char
//
// A request is accepted, then shifted bit by bit, VALUE_BITS (32) shifts, into
// the row of digit cells (10); the cells then pass their digits up, most
// significant first, to skip leading zeros and emit characters.
// Reset is synchronous and clears the controller and the output valid.
// A stalled result holds in the output register; digit emission waits for it,
// and the next request is taken once the last character is in that register.
module unsigned_to_ascii_digits (
   input  logic                                 clock,
   input  logic                                 reset,
   // tdata: value [VALUE_BITS-1:0], zero fill above.
   input  logic [utad_pkg::REQ_TDATA_BITS-1:0]  req_tdata,
   // tuser: use_hex [0].
   input  logic                                 req_tuser,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata: char_code [6:0], zero at bit 7.
   output logic [utad_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready
);

`include "unsigned_to_ascii_digits_defines.svh"

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_CONVERT = 3'b010,
      ST_EMIT    = 3'b100
   } state_type;

   state_type                              state_ff, state_in;
   logic [utad_pkg::VALUE_BITS-1:0]        value_ff, value_in;
   logic                                   hex_ff, hex_in;
   logic [utad_pkg::BIT_CNT_BITS-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [utad_pkg::DIG_CNT_BITS-1:0]      dig_cnt_ff, dig_cnt_in;
   logic                                   started_ff, started_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [utad_pkg::CHAR_BITS-1:0]         rsp_char_ff, rsp_char_in;
   logic                                   rsp_last_ff, rsp_last_in;

   utad_pkg::cell_ctrl_type                cell_ctrl;
   logic                                   bit_chain [utad_pkg::DIGIT_CELLS+1];
   logic [utad_pkg::DIGIT_BITS-1:0]        digit_chain [utad_pkg::DIGIT_CELLS+1];
   logic [utad_pkg::DIGIT_BITS-1:0]        top_digit;

   logic req_accept;
   logic is_last;
   logic skip_zero;
   logic out_free;
   logic load_out;

   // Row of digit cells, least significant digit at cell zero.
   assign bit_chain[0]   = value_ff[utad_pkg::VALUE_BITS-1];
   assign digit_chain[0] = '0;

   for (genvar i = 0; i < utad_pkg::DIGIT_CELLS; i++) begin : g_cell
      utad_digit_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .bit_in    (bit_chain[i]),
         .digit_in  (digit_chain[i]),
         .bit_out   (bit_chain[i+1]),
         .digit_out (digit_chain[i+1])
      );
   end

   assign top_digit = digit_chain[utad_pkg::DIGIT_CELLS];

   // Handshake and emission decisions.
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign is_last    = (dig_cnt_ff == utad_pkg::DIG_CNT_BITS'(1));
   assign skip_zero  = (state_ff == ST_EMIT) && !started_ff && (top_digit == '0) && !is_last;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign load_out   = (state_ff == ST_EMIT) && !skip_zero && out_free;

   // Cell row operation for this cycle.
   always_comb begin
      cell_ctrl.hex = hex_ff;
      if (req_accept) begin
         cell_ctrl.op = utad_pkg::CELL_CLEAR;
      end else if (state_ff == ST_CONVERT) begin
         cell_ctrl.op = utad_pkg::CELL_BIT;
      end else if (skip_zero || load_out) begin
         cell_ctrl.op = utad_pkg::CELL_DIGIT;
      end else begin
         cell_ctrl.op = utad_pkg::CELL_HOLD;
      end
   end

   // Controller: load, bit shifts, then digit emission.
   always_comb begin
      state_in   = state_ff;
      value_in   = value_ff;
      hex_in     = hex_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      started_in = started_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               value_in   = req_tdata[utad_pkg::VALUE_BITS-1:0];
               hex_in     = req_tuser;
               bit_cnt_in = utad_pkg::BIT_CNT_BITS'(utad_pkg::VALUE_BITS);
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            value_in   = {value_ff[utad_pkg::VALUE_BITS-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - utad_pkg::BIT_CNT_BITS'(1);
            if (bit_cnt_ff == utad_pkg::BIT_CNT_BITS'(1)) begin
               dig_cnt_in = utad_pkg::DIG_CNT_BITS'(utad_pkg::DIGIT_CELLS);
               started_in = 1'b0;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (skip_zero) begin
               dig_cnt_in = dig_cnt_ff - utad_pkg::DIG_CNT_BITS'(1);
            end else if (load_out) begin
               dig_cnt_in = dig_cnt_ff - utad_pkg::DIG_CNT_BITS'(1);
               started_in = 1'b1;
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register in front of the result channel.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = utad_pkg::digit_to_ascii(top_digit);
         rsp_last_in  = is_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bit_cnt_ff   <= '0;
         dig_cnt_ff   <= '0;
         started_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bit_cnt_ff   <= bit_cnt_in;
         dig_cnt_ff   <= dig_cnt_in;
         started_ff   <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      hex_ff      <= hex_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tdata  = {{(utad_pkg::RSP_TDATA_BITS - utad_pkg::CHAR_BITS){1'b0}}, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // The row is wide enough that no bit ever leaves the top cell.
   `UTAD_ASSERT_IMPLIES(a_no_overflow, cell_ctrl.op == utad_pkg::CELL_BIT, !bit_chain[utad_pkg::DIGIT_CELLS], "digit row overflow")

   // The first character of a number is a leading zero only for the value zero.
   `UTAD_ASSERT_IMPLIES(a_no_lead_zero, load_out && !started_ff, (top_digit != '0) || is_last, "leading zero emitted")

   // Emission never runs past the last digit cell.
   `UTAD_ASSERT_IMPLIES(a_emit_count, state_ff == ST_EMIT, dig_cnt_ff != '0, "digit count exhausted in emit")

   // Decimal digits stay within 0 to 9 at the top of the row.
   `UTAD_ASSERT_IMPLIES(a_dec_digit, (state_ff == ST_EMIT) && !hex_ff, top_digit < utad_pkg::DEC_RADIX, "decimal digit out of range")

endmodule

// ===== hdl/utad_digit_cell.sv =====
// One digit cell: a shift stage, with add-3 in decimal mode, that also moves whole digits on.
module utad_digit_cell (
   input  logic                              clock,
   input  utad_pkg::cell_ctrl_type           ctrl,
   input  logic                              bit_in,
   input  logic [utad_pkg::DIGIT_BITS-1:0]   digit_in,
   output logic                              bit_out,
   output logic [utad_pkg::DIGIT_BITS-1:0]   digit_out
);

   logic [utad_pkg::DIGIT_BITS-1:0] digit_ff;
   logic [utad_pkg::DIGIT_BITS-1:0] digit_in_next;
   logic [utad_pkg::DIGIT_BITS-1:0] adj;

   // Decimal digits of five or more get three added before the shift.
   always_comb begin
      if (!ctrl.hex && (digit_ff >= utad_pkg::DEC_ADJUST_MIN)) begin
         adj = digit_ff + utad_pkg::DEC_ADJUST;
      end else begin
         adj = digit_ff;
      end
   end

   // Next digit for each row operation.
   always_comb begin
      case (ctrl.op)
         utad_pkg::CELL_CLEAR: digit_in_next = '0;
         utad_pkg::CELL_BIT:   digit_in_next = {adj[utad_pkg::DIGIT_BITS-2:0], bit_in};
         utad_pkg::CELL_DIGIT: digit_in_next = digit_in;
         default:              digit_in_next = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_next;
   end

   assign bit_out   = adj[utad_pkg::DIGIT_BITS-1];
   assign digit_out = digit_ff;

endmodule

// ===== tb/digit_stream_checker.sv =====
// Checker that predicts and compares the ASCII digit stream of the converter.
`timescale 1ns / 100ps

module digit_stream_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [utad_pkg::REQ_TDATA_BITS-1:0]  req_tdata,
   input  logic                                 req_tuser,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [utad_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata,
   input  logic                                 rsp_tlast,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output int                                   fail_count,
   output int                                   pending
);
   import utad_pkg::*;

   // One expected character of the stream.
   typedef struct packed {
      logic [CHAR_BITS-1:0] code;
      logic                 last;
   } due_char_type;

   localparam logic [DIGIT_BITS-1:0] TEN = 4'd10;

   due_char_type due_chars[$];

   // Queue the characters of one number, most significant digit first.
   function automatic void spell_number(input logic [VALUE_BITS-1:0] value, input logic hex);
      logic [DIGIT_BITS-1:0] digits[$];
      logic [VALUE_BITS-1:0] rest;
      logic [DIGIT_BITS-1:0] d;
      due_char_type          c;
      rest = value;
      do begin
         if (hex) begin
            d    = rest[DIGIT_BITS-1:0];
            rest = rest >> DIGIT_BITS;
         end else begin
            d    = DIGIT_BITS'(rest % VALUE_BITS'(TEN));
            rest = rest / VALUE_BITS'(TEN);
         end
         digits.push_front(d);
      end while (rest != '0);
      for (int k = 0; k < digits.size(); k++) begin
         if (digits[k] < TEN) begin
            c.code = ASCII_ZERO + CHAR_BITS'(digits[k]);
         end else begin
            c.code = ASCII_A + CHAR_BITS'(digits[k] - TEN);
         end
         c.last = (k == digits.size() - 1);
         due_chars.push_back(c);
      end
   endfunction

   // Compare each accepted character, then expand each accepted request.
   always @(posedge clock) begin : watch
      due_char_type              head;
      logic [RSP_TDATA_BITS-1:0] want_data;
      int                        errors;
      errors = 0;
      if (reset) begin
         due_chars.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_chars.size() == 0) begin
               $display("%0t: unexpected character: expected none, actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               head      = due_chars.pop_front();
               want_data = '0;
               want_data[CHAR_BITS-1:0] = head.code;
               if (rsp_tdata !== want_data) begin
                  $display("%0t: char_code mismatch: expected %h, actual %h",
                           $time, want_data, rsp_tdata);
                  errors++;
               end
               if (rsp_tlast !== head.last) begin
                  $display("%0t: last_char mismatch: expected %b, actual %b",
                           $time, head.last, rsp_tlast);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            spell_number(req_tdata[VALUE_BITS-1:0], req_tuser);
         end
      end
      fail_count <= fail_count + errors;
      pending    <= due_chars.size();
   end

endmodule

// ===== tb/tb.sv =====
// Testbench top: drives numbers into the converter and gives the verdict.
`timescale 1ns / 100ps

module tb;
   import utad_pkg::*;

   localparam int RANDOM_NUMBERS = 300;
   localparam int DRAIN_CYCLES   = 60;

   logic                      clock = 1'b0;
   logic                      reset;
   logic [REQ_TDATA_BITS-1:0] req_tdata;
   logic                      req_tuser;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      rsp_tlast;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic                      steady;
   int                        fail_count;
   int                        pending;

   unsigned_to_ascii_digits u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   digit_stream_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The result side stalls now and then, except during the steady stretch.
   always @(posedge clock) begin
      rsp_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 7);
   end

   // Offer one number and hold it until the converter takes the request.
   task automatic send_number(input logic [VALUE_BITS-1:0] value, input logic hex);
      while (!steady && $urandom_range(0, 99) < 7) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_BITS'(value);
      req_tuser  <= hex;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      logic [VALUE_BITS-1:0] value;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      steady     <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Zero, all ones, digit and carry boundaries in both radixes.
      send_number(32'd0, 1'b0);
      send_number(32'd0, 1'b1);
      send_number(32'hFFFF_FFFF, 1'b0);
      send_number(32'hFFFF_FFFF, 1'b1);
      send_number(32'd1, 1'b0);
      send_number(32'd9, 1'b0);
      send_number(32'd10, 1'b0);
      send_number(32'd9, 1'b1);
      send_number(32'd10, 1'b1);
      send_number(32'd15, 1'b1);
      send_number(32'd16, 1'b1);
      send_number(32'd999_999_999, 1'b0);
      send_number(32'd1_000_000_000, 1'b0);
      send_number(32'd1_234_567_890, 1'b0);
      send_number(32'hF000_0000, 1'b1);
      send_number(32'h1000_0000, 1'b1);
      send_number(32'h0FFF_FFFF, 1'b1);
      send_number(32'hABCD_EF01, 1'b1);
      send_number(32'h8000_0000, 1'b0);
      send_number(32'h8000_0000, 1'b1);
      send_number(32'd100, 1'b0);
      send_number(32'h0000_00FA, 1'b1);

      // Random numbers of every length, with a stretch where neither side idles.
      for (int i = 0; i < RANDOM_NUMBERS; i++) begin
         steady <= (i >= 100 && i < 160);
         case ($urandom_range(0, 3))
            0: value = $urandom;
            1: value = VALUE_BITS'($urandom_range(0, 20));
            default: value = $urandom >> $urandom_range(0, VALUE_BITS - 1);
         endcase
         send_number(value, 1'($urandom_range(0, 1)));
      end
      req_tvalid <= 1'b0;
      steady     <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS unsigned_to_ascii_digits");
      end else begin
         $display("FAIL unsigned_to_ascii_digits");
      end
      $finish;
   end

   // Guard against a hang.
   initial begin
      #2_000_000;
      $display("FAIL unsigned_to_ascii_digits");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/utad_pkg.sv
hdl/utad_digit_cell.sv
hdl/unsigned_to_ascii_digits.sv
tb/digit_stream_checker.sv
tb/tb.sv
